// File: rtl/bsf_pkg.sv
// Shared types, constants and tap-table functions for the B-spline smoothing filter.
package bsf_pkg;

  localparam int KS_W      = 5;
  localparam int KS_TOP    = (1 << KS_W) - 1;
  localparam int CNT_W     = 6;
  localparam int CNT_MAX   = (1 << CNT_W) - 1;
  localparam int Q_DEPTH   = 2;

  typedef struct packed {
    logic emit;
    logic last_res;
    logic clear;
  } bsf_ctl_t;

  // Numerator of B3(u/d) over 6*d^3 for tap k, with u = |4k - 2d|.
  function automatic longint spline_num(input longint d, input longint k);
    longint u;
    longint t;
    longint n;
    u = 4 * k - 2 * d;
    if (u < 0) u = -u;
    n = 0;
    if (u < d) begin
      n = 4 * d * d * d - 3 * u * u * (2 * d - u);
    end else if (u < 2 * d) begin
      t = 2 * d - u;
      n = t * t * t;
    end
    return n;
  endfunction

  function automatic longint spline_sum(input longint d);
    longint acc;
    acc = 0;
    for (longint k = 0; k <= 2 * d; k++) acc += spline_num(d, k);
    return acc;
  endfunction

endpackage

// File: rtl/bsf_front.sv
// Front end: takes samples, tracks sequence position and issues shift/emit ops, incl. flush.
module bsf_front #(
  parameter int SW    = 16,
  parameter int ROW_W = 4
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [ROW_W-1:0]       half_size,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic signed [SW-1:0]   in_sample,
  input  logic                   in_last,
  output logic                   q_push,
  input  logic                   q_ready,
  output logic signed [SW-1:0]   q_sample,
  output bsf_pkg::bsf_ctl_t      q_ctl,
  output logic                   flushing
);

  localparam int CW = bsf_pkg::CNT_W;
  localparam int EW = CW + 1;

  logic [CW-1:0]    seen_r, seen_nxt;
  logic [CW-1:0]    fcnt_r, fcnt_nxt;
  logic [ROW_W-1:0] f_r, f_nxt;
  logic             flush_r, flush_nxt;
  logic [CW-1:0]    cnt_inc;
  logic             in_xfer;
  logic [EW-1:0]    f_lhs, f_rhs;
  logic             f_final;

  assign in_stall = flush_r || !q_ready;
  assign in_xfer  = in_valid && !in_stall;
  assign flushing = flush_r;

  assign cnt_inc = (seen_r == CW'(bsf_pkg::CNT_MAX)) ? seen_r : seen_r + CW'(1);
  assign f_lhs   = EW'(fcnt_r) + EW'(f_r);
  assign f_rhs   = EW'(half_size) + EW'(1);
  assign f_final = (f_r == half_size);

  always_comb begin
    q_push   = 1'b0;
    q_sample = in_sample;
    q_ctl    = '0;
    if (flush_r) begin
      q_push          = q_ready;
      q_sample        = '0;
      q_ctl.emit      = (f_lhs >= f_rhs);
      q_ctl.last_res  = f_final;
      q_ctl.clear     = f_final;
    end else begin
      q_push          = in_xfer;
      q_ctl.emit      = (cnt_inc > CW'(half_size));
      q_ctl.last_res  = in_last && (half_size == '0);
      q_ctl.clear     = in_last && (half_size == '0);
    end
  end

  always_comb begin
    seen_nxt  = seen_r;
    fcnt_nxt  = fcnt_r;
    f_nxt     = f_r;
    flush_nxt = flush_r;
    if (flush_r) begin
      if (q_ready) begin
        if (f_final) begin
          flush_nxt = 1'b0;
        end else begin
          f_nxt = f_r + ROW_W'(1);
        end
      end
    end else if (in_xfer) begin
      if (in_last) begin
        seen_nxt = '0;
        if (half_size != '0) begin
          flush_nxt = 1'b1;
          f_nxt     = ROW_W'(1);
          fcnt_nxt  = cnt_inc;
        end
      end else begin
        seen_nxt = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      fcnt_r  <= '0;
      f_r     <= '0;
      flush_r <= 1'b0;
    end else begin
      seen_r  <= seen_nxt;
      fcnt_r  <= fcnt_nxt;
      f_r     <= f_nxt;
      flush_r <= flush_nxt;
    end
  end

endmodule

// File: rtl/bsf_queue.sv
// Two-entry op queue between front end and datapath.
module bsf_queue #(
  parameter int SW = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 push_ready,
  input  logic signed [SW-1:0] push_sample,
  input  bsf_pkg::bsf_ctl_t    push_ctl,
  input  logic                 pop,
  output logic                 pop_valid,
  output logic signed [SW-1:0] pop_sample,
  output bsf_pkg::bsf_ctl_t    pop_ctl
);

  localparam int DEPTH = bsf_pkg::Q_DEPTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);

  logic signed [SW-1:0] sample_r [DEPTH];
  bsf_pkg::bsf_ctl_t    ctl_r    [DEPTH];
  logic [AW-1:0]        wr_r, rd_r;
  logic [NW-1:0]        cnt_r, cnt_nxt;
  logic                 do_push, do_pop;

  assign push_ready = (cnt_r != NW'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_sample = sample_r[rd_r];
  assign pop_ctl    = ctl_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + NW'(1);
    if (!do_push && do_pop) cnt_nxt = cnt_r - NW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) wr_r <= (wr_r == AW'(DEPTH - 1)) ? '0 : wr_r + AW'(1);
      if (do_pop)  rd_r <= (rd_r == AW'(DEPTH - 1)) ? '0 : rd_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      sample_r[wr_r] <= push_sample;
      ctl_r[wr_r]    <= push_ctl;
    end
  end

endmodule

// File: rtl/bsf_back.sv
// Datapath: delay line, tap table, multiplier lanes, registered adder tree, round and saturate.
module bsf_back #(
  parameter int SW    = 16,
  parameter int CF    = 16,
  parameter int NTAP  = 31,
  parameter int NROW  = 16,
  parameter int ROW_W = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [ROW_W-1:0]     half_size,
  input  logic                 q_valid,
  output logic                 q_pop,
  input  logic signed [SW-1:0] q_sample,
  input  bsf_pkg::bsf_ctl_t    q_ctl,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [SW-1:0] out_smoothed,
  output logic                 out_last_res
);

  localparam int COEF_W = CF + 1;
  localparam int PROD_W = SW + COEF_W + 1;
  localparam int ACC_W  = PROD_W + 5;
  localparam int G1     = (NTAP + 3) / 4;
  localparam int G2     = (G1 + 3) / 4;
  localparam logic signed [ACC_W-1:0] HALF =
    {{(ACC_W-1){1'b0}}, 1'b1} << (CF - 1);
  localparam logic signed [ACC_W-1:0] SMAX = {{(ACC_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SMIN = {{(ACC_W-SW+1){1'b1}}, {(SW-1){1'b0}}};

  logic [COEF_W-1:0]      tap_tab [NROW][NTAP];
  logic [COEF_W-1:0]      coef_r  [NTAP];
  logic signed [SW-1:0]   dl_r    [NTAP];
  logic signed [SW-1:0]   sh      [NTAP];
  logic signed [PROD_W-1:0] p1_r  [NTAP];
  logic signed [ACC_W-1:0]  s2_r  [G1];
  logic signed [ACC_W-1:0]  s3_r  [G2];
  logic signed [ACC_W-1:0]  s2_nxt [G1];
  logic signed [ACC_W-1:0]  s3_nxt [G2];
  logic signed [ACC_W-1:0]  tot, rnd, qv;
  logic signed [SW-1:0]   res;
  logic                   v1_r, v2_r, v3_r, vo_r;
  logic                   l1_r, l2_r, l3_r, lo_r;
  logic signed [SW-1:0]   out_r;
  logic                   adv;

  for (genvar gr = 0; gr < NROW; gr++) begin : g_row
    for (genvar gj = 0; gj < NTAP; gj++) begin : g_lane
      localparam longint D   = 2 * gr;
      localparam longint N   = bsf_pkg::spline_num(D, gj);
      localparam longint S   = (D == 0) ? 1 : bsf_pkg::spline_sum(D);
      localparam longint TAP = (D == 0) ? ((gj == 0) ? (longint'(1) << CF) : 0)
                                        : (((N << CF) + S / 2) / S);
      assign tap_tab[gr][gj] = COEF_W'(TAP);
    end
  end

  assign adv       = !vo_r || !out_stall;
  assign q_pop     = adv && q_valid;
  assign out_valid = vo_r;
  assign out_smoothed = out_r;
  assign out_last_res = lo_r;

  always_comb begin
    sh[0] = q_sample;
    for (int j = 1; j < NTAP; j++) sh[j] = dl_r[j-1];
  end

  always_comb begin
    for (int g = 0; g < G1; g++) begin
      s2_nxt[g] = '0;
      for (int i = 0; i < 4; i++) begin
        if (4 * g + i < NTAP) s2_nxt[g] = s2_nxt[g] + ACC_W'(p1_r[4*g+i]);
      end
    end
    for (int h = 0; h < G2; h++) begin
      s3_nxt[h] = '0;
      for (int i = 0; i < 4; i++) begin
        if (4 * h + i < G1) s3_nxt[h] = s3_nxt[h] + s2_r[4*h+i];
      end
    end
  end

  always_comb begin
    tot = '0;
    for (int h = 0; h < G2; h++) tot = tot + s3_r[h];
    rnd = tot + HALF;
    qv  = rnd >>> CF;
    if (qv > SMAX) begin
      res = SMAX[SW-1:0];
    end else if (qv < SMIN) begin
      res = SMIN[SW-1:0];
    end else begin
      res = qv[SW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < NTAP; j++) coef_r[j] <= tap_tab[half_size][j];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < NTAP; j++) dl_r[j] <= '0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (q_pop) begin
        for (int j = 0; j < NTAP; j++) dl_r[j] <= q_ctl.clear ? '0 : sh[j];
      end
      if (adv) begin
        v1_r <= q_pop && q_ctl.emit;
        v2_r <= v1_r;
        v3_r <= v2_r;
        vo_r <= v3_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < NTAP; j++) begin
        p1_r[j] <= PROD_W'($signed(sh[j]) * $signed({1'b0, coef_r[j]}));
      end
      l1_r <= q_ctl.last_res;
      s2_r <= s2_nxt;
      l2_r <= l1_r;
      s3_r <= s3_nxt;
      l3_r <= l2_r;
      out_r <= res;
      lo_r  <= l3_r;
    end
  end

endmodule

// File: rtl/cubic_bspline_smoothing_fir.sv
// Top level of the cubic B-spline smoothing filter: config register, front end, queue, datapath.
// The filter takes one sample per clock while in_stall is low and, in steady state with out_stall
// low, delivers one smoothed sample per clock. The datapath is a row of parallel multiplier lanes
// and a registered adder tree; a completing sample reaches out_valid via the op queue, product,
// adder-tree and output registers. When a sample marked last arrives with an effective size m
// above 1, the front end issues (m-1)/2 flush steps, one per cycle while the op queue has room;
// in_stall is high during the flush and while the op queue is full. Taps come from a table built
// at elaboration, one row per odd size; cfg_taps may only be changed while the filter is idle.
module cubic_bspline_smoothing_fir #(
  parameter int MAX_TAPS       = 31,
  parameter int SAMPLE_WIDTH   = 16,
  parameter int COEF_FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bsf_pkg::KS_W-1:0]       cfg_taps,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
  input  logic                           in_last,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_smoothed,
  output logic                           out_last_res
);

  localparam int KW      = bsf_pkg::KS_W;
  localparam int TOP_ODD = (MAX_TAPS % 2 == 1) ? MAX_TAPS : MAX_TAPS - 1;
  localparam int NTAP    = (TOP_ODD > bsf_pkg::KS_TOP) ? bsf_pkg::KS_TOP : TOP_ODD;
  localparam int NROW    = (NTAP + 1) / 2;
  localparam int ROW_W   = $clog2(NROW);

  logic [KW-1:0]                 ks_r;
  logic [KW-1:0]                 m_odd, m_eff;
  logic [ROW_W-1:0]              half_size;
  logic                          q_push, q_ready, q_pop, q_valid;
  logic signed [SAMPLE_WIDTH-1:0] f_sample, b_sample;
  bsf_pkg::bsf_ctl_t             f_ctl, b_ctl;
  logic                          flushing;

  assign cfg_ready = 1'b1;
  assign m_odd     = ks_r | KW'(1);
  assign m_eff     = (m_odd > KW'(NTAP)) ? KW'(NTAP) : m_odd;
  assign half_size = m_eff[ROW_W:1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ks_r <= KW'(1);
    end else if (cfg_valid && cfg_ready) begin
      ks_r <= cfg_taps;
    end
  end

  bsf_front #(
    .SW    (SAMPLE_WIDTH),
    .ROW_W (ROW_W)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .half_size (half_size),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_sample (in_sample),
    .in_last   (in_last),
    .q_push    (q_push),
    .q_ready   (q_ready),
    .q_sample  (f_sample),
    .q_ctl     (f_ctl),
    .flushing  (flushing)
  );

  bsf_queue #(
    .SW (SAMPLE_WIDTH)
  ) u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (q_push),
    .push_ready  (q_ready),
    .push_sample (f_sample),
    .push_ctl    (f_ctl),
    .pop         (q_pop),
    .pop_valid   (q_valid),
    .pop_sample  (b_sample),
    .pop_ctl     (b_ctl)
  );

  bsf_back #(
    .SW    (SAMPLE_WIDTH),
    .CF    (COEF_FRAC_BITS),
    .NTAP  (NTAP),
    .NROW  (NROW),
    .ROW_W (ROW_W)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .half_size    (half_size),
    .q_valid      (q_valid),
    .q_pop        (q_pop),
    .q_sample     (b_sample),
    .q_ctl        (b_ctl),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_smoothed (out_smoothed),
    .out_last_res (out_last_res)
  );

`ifndef NO_ASSERTIONS
  a_flush_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    flushing |-> in_stall)
    else $error("input transfer possible during flush");

  a_last_starts_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last && (half_size != '0)) |=> flushing)
    else $error("last sample did not start flush");

  a_last_no_flush: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_last && (half_size == '0)) |=> !flushing)
    else $error("flush started for pass-through size");
`endif

endmodule
